@@ rtl/bpa_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Bitmap page allocator package
// Shared sizes, codes, word types and the controller/datapath interface.
// ============================================================================
package bpa_pkg;

    // Pool and memory geometry.
    localparam int POOL_PAGES  = 4096;
    localparam int PAGE_BYTES  = 4096;
    localparam int WORD_BITS   = 32;
    localparam int ROWS        = POOL_PAGES / WORD_BITS;
    localparam int ROW_W       = $clog2(ROWS);
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int PAGE_W      = ROW_W + BIT_W;
    localparam int LEN_W       = PAGE_W + 1;
    localparam int PAGE_SH     = $clog2(PAGE_BYTES);

    // The virtual run scan looks at one chunk of a row per cycle, pausing to read each new row.
    localparam int CHUNK_BITS  = 8;
    localparam int CHUNKS      = WORD_BITS / CHUNK_BITS;
    localparam int CHUNK_W     = $clog2(CHUNKS);
    localparam int CHUNK_IDX_W = $clog2(CHUNK_BITS);

    // Field and register widths.
    localparam int ADDR_W      = 32;
    localparam int COUNT_W     = 12;
    localparam int CNT_W       = 13;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_VIRT_BASE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERN_BASE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_USER_BASE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERN_PAGES  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_USER_PAGES  = 3'd4;

    // Register reset values.
    localparam logic [ADDR_W-1:0] VIRT_BASE_RST = 32'hC010_0000;
    localparam logic [ADDR_W-1:0] PHYS_BASE_RST = 32'h0020_0000;

    // Request codes.
    localparam logic OP_VIRT     = 1'b0;
    localparam logic OP_PHYS     = 1'b1;
    localparam logic POOL_KERNEL = 1'b0;
    localparam logic POOL_USER   = 1'b1;

    typedef struct packed {
        logic               op;
        logic               pool;
        logic [COUNT_W-1:0] count;
    } t_in_word;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] address;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic fail;
        logic scan_rd;
        logic scan_chk;
        logic mark_rd;
        logic mark_wr;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic bad;
        logic phys;
        logic hit;
        logic last;
        logic chunk_last;
        logic mark_last;
        logic out_free;
    } t_status;

endpackage

@@ rtl/bpa_map_ram.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Bitmap row memory
// One occupancy bitmap stored as rows, with a per-row valid flag so that a
// row never written since reset reads as all free.
// ============================================================================
module bpa_map_ram (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_we,
    input  logic [bpa_pkg::ROW_W-1:0]           i_waddr,
    input  logic [bpa_pkg::WORD_BITS-1:0]       i_wdata,
    input  logic                                i_re,
    input  logic [bpa_pkg::ROW_W-1:0]           i_raddr,
    output logic [bpa_pkg::WORD_BITS-1:0]       o_rdata
);

    logic [bpa_pkg::WORD_BITS-1:0] r_mem [bpa_pkg::ROWS];
    logic [bpa_pkg::ROWS-1:0]      r_vld;
    logic [bpa_pkg::WORD_BITS-1:0] r_rdata;
    logic                          r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

@@ rtl/bpa_datapath.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Bitmap page allocator datapath
// Configuration registers, the three bitmaps, the first-fit scan logic, the
// row marking logic and the result register.
// ============================================================================
module bpa_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bpa_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  bpa_pkg::t_in_word                 i_in_data,
    input  bpa_pkg::t_cmd                     i_cmd,
    output bpa_pkg::t_status                  o_status,
    output logic                              o_out_valid,
    output bpa_pkg::t_out_word                o_out_data,
    input  logic                              i_out_stall
);

    // Configuration.
    logic [bpa_pkg::ADDR_W-1:0] r_virt_base;
    logic [bpa_pkg::ADDR_W-1:0] r_kern_base;
    logic [bpa_pkg::ADDR_W-1:0] r_user_base;
    logic [bpa_pkg::CNT_W-1:0]  r_kern_pages;
    logic [bpa_pkg::CNT_W-1:0]  r_user_pages;

    // Request in progress.
    logic                              r_op;
    logic                              r_pool;
    logic [bpa_pkg::COUNT_W-1:0]       r_want;
    logic [bpa_pkg::LEN_W-1:0]         r_len;
    logic [bpa_pkg::ROW_W-1:0]         r_row;
    logic [bpa_pkg::CHUNK_W-1:0]       r_chunk;
    logic [bpa_pkg::LEN_W-1:0]         r_run;
    logic [bpa_pkg::PAGE_W-1:0]        r_start;
    logic [bpa_pkg::PAGE_W-1:0]        r_end;
    logic                              r_res_ok;
    logic [bpa_pkg::ADDR_W-1:0]        r_res_addr;

    logic [bpa_pkg::CNT_W-1:0]         sel_pages;
    logic [bpa_pkg::LEN_W-1:0]         n_len;
    logic [bpa_pkg::ADDR_W-1:0]        sel_base;
    logic                              sel_virt;
    logic                              sel_kern;
    logic                              sel_user;
    logic                              mem_re;
    logic                              mem_we;
    logic [bpa_pkg::WORD_BITS-1:0]     rd_virt;
    logic [bpa_pkg::WORD_BITS-1:0]     rd_kern;
    logic [bpa_pkg::WORD_BITS-1:0]     rd_user;
    logic [bpa_pkg::WORD_BITS-1:0]     rd_data;
    logic [bpa_pkg::WORD_BITS-1:0]     wr_data;

    // Scan logic.
    logic [bpa_pkg::CHUNK_BITS-1:0]    c_bits;
    logic [bpa_pkg::CHUNK_BITS-1:0]    c_used;
    logic [bpa_pkg::LEN_W-1:0]         c_run [bpa_pkg::CHUNK_BITS];
    logic [bpa_pkg::CHUNK_BITS-1:0]    c_hit;
    logic [bpa_pkg::CHUNK_IDX_W-1:0]   c_last_used [bpa_pkg::CHUNK_BITS];
    logic [bpa_pkg::CHUNK_BITS-1:0]    c_all_free;
    logic [bpa_pkg::CHUNK_IDX_W-1:0]   c_sel;
    logic [bpa_pkg::PAGE_W-1:0]        v_end;
    logic [bpa_pkg::PAGE_W-1:0]        v_start;
    logic [bpa_pkg::WORD_BITS-1:0]     p_free;
    logic [bpa_pkg::BIT_W-1:0]         p_sel;
    logic                              hit;
    logic [bpa_pkg::PAGE_W-1:0]        hit_start;
    logic [bpa_pkg::PAGE_W-1:0]        hit_end;
    logic                              scan_last;

    // Marking logic.
    logic [bpa_pkg::BIT_W-1:0]         m_lo;
    logic [bpa_pkg::BIT_W-1:0]         m_hi;
    logic [bpa_pkg::WORD_BITS-1:0]     m_mask;
    logic                              m_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_virt_base  <= bpa_pkg::VIRT_BASE_RST;
            r_kern_base  <= bpa_pkg::PHYS_BASE_RST;
            r_user_base  <= bpa_pkg::PHYS_BASE_RST;
            r_kern_pages <= '0;
            r_user_pages <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bpa_pkg::REG_VIRT_BASE:  r_virt_base  <= i_cfg_data[bpa_pkg::ADDR_W-1:0];
                bpa_pkg::REG_KERN_BASE:  r_kern_base  <= i_cfg_data[bpa_pkg::ADDR_W-1:0];
                bpa_pkg::REG_USER_BASE:  r_user_base  <= i_cfg_data[bpa_pkg::ADDR_W-1:0];
                bpa_pkg::REG_KERN_PAGES: r_kern_pages <= i_cfg_data[bpa_pkg::CNT_W-1:0];
                bpa_pkg::REG_USER_PAGES: r_user_pages <= i_cfg_data[bpa_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Map length: the page count register, limited to the pool size.
    assign sel_pages = (i_in_data.pool == bpa_pkg::POOL_USER) ? r_user_pages : r_kern_pages;
    assign n_len = (sel_pages > bpa_pkg::CNT_W'(bpa_pkg::POOL_PAGES))
                 ? bpa_pkg::LEN_W'(bpa_pkg::POOL_PAGES) : bpa_pkg::LEN_W'(sel_pages);

    assign sel_virt = (r_op == bpa_pkg::OP_VIRT);
    assign sel_kern = (r_op == bpa_pkg::OP_PHYS) && (r_pool == bpa_pkg::POOL_KERNEL);
    assign sel_user = (r_op == bpa_pkg::OP_PHYS) && (r_pool == bpa_pkg::POOL_USER);
    assign sel_base = sel_virt ? r_virt_base : (sel_user ? r_user_base : r_kern_base);

    assign mem_re  = i_cmd.scan_rd || i_cmd.mark_rd;
    assign mem_we  = i_cmd.mark_wr;
    assign rd_data = sel_virt ? rd_virt : (sel_user ? rd_user : rd_kern);
    assign wr_data = rd_data | m_mask;

    bpa_map_ram u_virt_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we && sel_virt),
        .i_waddr (r_row),
        .i_wdata (wr_data),
        .i_re    (mem_re && sel_virt),
        .i_raddr (r_row),
        .o_rdata (rd_virt)
    );

    bpa_map_ram u_kern_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we && sel_kern),
        .i_waddr (r_row),
        .i_wdata (wr_data),
        .i_re    (mem_re && sel_kern),
        .i_raddr (r_row),
        .o_rdata (rd_kern)
    );

    bpa_map_ram u_user_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we && sel_user),
        .i_waddr (r_row),
        .i_wdata (wr_data),
        .i_re    (mem_re && sel_user),
        .i_raddr (r_row),
        .o_rdata (rd_user)
    );

    // Virtual run scan over one chunk. Pages at or beyond the map length
    // count as used. The run ending at each bit is either the carried run
    // plus the bits so far, when the chunk is free up to it, or the distance
    // from the last used bit below it.
    assign c_bits = rd_data[{r_chunk, bpa_pkg::CHUNK_IDX_W'(0)} +: bpa_pkg::CHUNK_BITS];

    always_comb begin
        for (int k = 0; k < bpa_pkg::CHUNK_BITS; k++) begin
            c_used[k] = c_bits[k] ||
                ({1'b0, r_row, r_chunk, bpa_pkg::CHUNK_IDX_W'(k)} >= r_len);
        end
        for (int k = 0; k < bpa_pkg::CHUNK_BITS; k++) begin
            c_all_free[k]  = 1'b1;
            c_last_used[k] = '0;
            for (int j = 0; j <= k; j++) begin
                if (c_used[j]) begin
                    c_all_free[k]  = 1'b0;
                    c_last_used[k] = bpa_pkg::CHUNK_IDX_W'(j);
                end
            end
            c_run[k] = c_all_free[k] ? r_run + bpa_pkg::LEN_W'(k + 1)
                     : bpa_pkg::LEN_W'(k) - bpa_pkg::LEN_W'(c_last_used[k]);
            c_hit[k] = (c_run[k] >= {1'b0, r_want});
        end
        c_sel = '0;
        for (int k = bpa_pkg::CHUNK_BITS - 1; k >= 0; k--) begin
            if (c_hit[k]) begin
                c_sel = bpa_pkg::CHUNK_IDX_W'(k);
            end
        end
    end

    assign v_end   = {r_row, r_chunk, c_sel};
    assign v_start = v_end + bpa_pkg::PAGE_W'(1) - r_want[bpa_pkg::PAGE_W-1:0];

    // Single page scan over a whole row: the lowest free page in the map.
    always_comb begin
        for (int b = 0; b < bpa_pkg::WORD_BITS; b++) begin
            p_free[b] = !rd_data[b] && ({1'b0, r_row, bpa_pkg::BIT_W'(b)} < r_len);
        end
        p_sel = '0;
        for (int b = bpa_pkg::WORD_BITS - 1; b >= 0; b--) begin
            if (p_free[b]) begin
                p_sel = bpa_pkg::BIT_W'(b);
            end
        end
    end

    always_comb begin
        if (r_op == bpa_pkg::OP_PHYS) begin
            hit       = |p_free;
            hit_start = {r_row, p_sel};
            hit_end   = {r_row, p_sel};
            scan_last = ({1'b0, r_row, bpa_pkg::BIT_W'(0)}
                        + bpa_pkg::LEN_W'(bpa_pkg::WORD_BITS)) >= r_len;
        end else begin
            hit       = |c_hit;
            hit_start = v_start;
            hit_end   = v_end;
            scan_last = ({1'b0, r_row, r_chunk, bpa_pkg::CHUNK_IDX_W'(0)}
                        + bpa_pkg::LEN_W'(bpa_pkg::CHUNK_BITS)) >= r_len;
        end
    end

    // Bits of the current row that fall inside the allocated run.
    assign m_lo   = (r_row == r_start[bpa_pkg::PAGE_W-1:bpa_pkg::BIT_W])
                  ? r_start[bpa_pkg::BIT_W-1:0] : '0;
    assign m_last = (r_row == r_end[bpa_pkg::PAGE_W-1:bpa_pkg::BIT_W]);
    assign m_hi   = m_last ? r_end[bpa_pkg::BIT_W-1:0] : '1;
    assign m_mask = ({bpa_pkg::WORD_BITS{1'b1}} << m_lo)
                  & ({bpa_pkg::WORD_BITS{1'b1}} >> (bpa_pkg::BIT_W'(bpa_pkg::WORD_BITS - 1) - m_hi));

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op    <= i_in_data.op;
            r_pool  <= i_in_data.pool;
            r_want  <= (i_in_data.op == bpa_pkg::OP_PHYS)
                     ? bpa_pkg::COUNT_W'(1) : i_in_data.count;
            r_len   <= n_len;
            r_row   <= '0;
            r_chunk <= '0;
            r_run   <= '0;
        end else if (i_cmd.scan_chk) begin
            if (hit) begin
                r_start <= hit_start;
                r_end   <= hit_end;
                r_row   <= hit_start[bpa_pkg::PAGE_W-1:bpa_pkg::BIT_W];
            end else if (r_op == bpa_pkg::OP_PHYS ||
                         r_chunk == bpa_pkg::CHUNK_W'(bpa_pkg::CHUNKS - 1)) begin
                r_row   <= r_row + bpa_pkg::ROW_W'(1);
                r_chunk <= '0;
                r_run   <= c_run[bpa_pkg::CHUNK_BITS-1];
            end else begin
                r_chunk <= r_chunk + bpa_pkg::CHUNK_W'(1);
                r_run   <= c_run[bpa_pkg::CHUNK_BITS-1];
            end
        end else if (i_cmd.mark_wr && !m_last) begin
            r_row <= r_row + bpa_pkg::ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fail) begin
            r_res_ok   <= 1'b0;
            r_res_addr <= '0;
        end else if (i_cmd.mark_wr && m_last) begin
            r_res_ok   <= 1'b1;
            r_res_addr <= sel_base + (bpa_pkg::ADDR_W'(r_start) << bpa_pkg::PAGE_SH);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_out_data.ok      <= r_res_ok;
            o_out_data.address <= r_res_addr;
        end
    end

    assign o_status.bad = ((r_op == bpa_pkg::OP_VIRT) && (r_pool == bpa_pkg::POOL_USER))
                        || (r_want == '0) || ({1'b0, r_want} > r_len);
    assign o_status.phys       = (r_op == bpa_pkg::OP_PHYS);
    assign o_status.hit        = hit;
    assign o_status.last       = scan_last;
    assign o_status.chunk_last = (r_chunk == bpa_pkg::CHUNK_W'(bpa_pkg::CHUNKS - 1));
    assign o_status.mark_last  = m_last;
    assign o_status.out_free   = !o_out_valid || !i_out_stall;

`ifndef SYNTHESIS
    a_mark_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mark_wr |-> (m_mask != '0))
        else $error("marking a row with an empty mask");

    a_hit_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan_chk && hit) |-> (({1'b0, hit_end} < r_len) && (hit_start <= hit_end)))
        else $error("found run lies outside the map");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.ok) |-> (o_out_data.address == '0))
        else $error("failed allocation carries a non-zero address");
`endif

endmodule

@@ rtl/bpa_ctrl.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Bitmap page allocator controller
// Sequences one request through check, scan, mark and result hand-off.
// ============================================================================
module bpa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bpa_pkg::t_status   i_status,
    output bpa_pkg::t_cmd      o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_CHECK    = 8'b0000_0010,
        S_SCAN_RD  = 8'b0000_0100,
        S_SCAN_CHK = 8'b0000_1000,
        S_MARK_RD  = 8'b0001_0000,
        S_MARK_WR  = 8'b0010_0000,
        S_DONE     = 8'b0100_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.bad) begin
                    o_cmd.fail = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                o_cmd.scan_chk = 1'b1;
                if (i_status.hit) begin
                    n_state = S_MARK_RD;
                end else if (i_status.last) begin
                    o_cmd.fail = 1'b1;
                    n_state    = S_DONE;
                end else if (i_status.phys || i_status.chunk_last) begin
                    n_state = S_SCAN_RD;
                end
            end
            S_MARK_RD: begin
                o_cmd.mark_rd = 1'b1;
                n_state       = S_MARK_WR;
            end
            S_MARK_WR: begin
                o_cmd.mark_wr = 1'b1;
                n_state       = i_status.mark_last ? S_DONE : S_MARK_RD;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

`ifndef SYNTHESIS
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !i_status.out_free) |=> (r_state == S_DONE))
        else $error("result dropped while the output register was full");
`endif

endmodule

@@ rtl/bitmap_page_allocator.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Bitmap page allocator
// First-fit page allocator over a kernel virtual map, a kernel physical map
// and a user physical map, one bit per page.
// ============================================================================
//
// Channel   Direction  Handshake                   Word
// -------   ---------  --------------------------  --------------------------
// in        input      i_in_valid / o_in_stall     op, pool, count
// out       output     o_out_valid / i_out_stall   ok, address
// cfg       input      i_cfg_we                    i_cfg_index, i_cfg_data
//
// A request is taken and checked in its own states, then the chosen map is scanned.
// A physical request reads and checks one 32-page row at a time; a virtual run is
// checked 8 pages per cycle, with a read of each new row in between, so the scan
// bounds the time on a full 4096-page map. The run is then marked, one row read
// and written at a time, and the result is handed over.
// The maps need no clearing pass after reset: a per-row valid flag makes
// unwritten rows read as free. A stalled result waits in the output
// register while the next word is already accepted and worked on.
//
module bitmap_page_allocator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration writes.
    input  logic                              i_cfg_we,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bpa_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Request channel.
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  bpa_pkg::t_in_word                 i_in_data,
    // Result channel.
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output bpa_pkg::t_out_word                o_out_data
);

    // The controller only decides what happens in each cycle; all storage
    // for the maps, the registers and the scan state sits in the datapath.
    bpa_pkg::t_cmd    cmd;
    bpa_pkg::t_status status;

    bpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The datapath takes the request word when the controller accepts it,
    // and owns the output register that separates the two channels.
    bpa_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
